@@ hdl/mtk_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mtk_pkg
// Types, constants and the letter table shared by the multi-tap key entry unit
// and its channel interfaces.
// ----------------------------------------------------------------------------
package mtk_pkg;

   localparam int CMD_W      = 2;
   localparam int KEY_W      = 3;
   localparam int PRESS_W    = 2;
   localparam int WAIT_W     = 4;
   localparam int LEN_W      = 4;
   localparam int CHAR_W     = 8;
   localparam int TIMEOUT_W  = 4;

   localparam logic [LEN_W-1:0]     MAX_WORD        = 4'd10;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET   = 4'd4;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_MIN     = 4'd1;

   localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_KEY    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SUBMIT = 2'd2;

   localparam logic [KEY_W-1:0]   KEY_NONE    = 3'd0;
   localparam logic [KEY_W-1:0]   KEY_ERASE   = 3'd7;
   localparam logic [PRESS_W-1:0] ERASE_PRESS = 2'd2;

   localparam logic [CHAR_W-1:0] CHAR_A     = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_E     = 8'h65;
   localparam logic [CHAR_W-1:0] CHAR_I     = 8'h69;
   localparam logic [CHAR_W-1:0] CHAR_M     = 8'h6D;
   localparam logic [CHAR_W-1:0] CHAR_Q     = 8'h71;
   localparam logic [CHAR_W-1:0] CHAR_U     = 8'h75;
   localparam logic [CHAR_W-1:0] CHAR_Y     = 8'h79;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;

   typedef struct packed {
      logic [LEN_W-1:0]  write_pos;
      logic [CHAR_W-1:0] char_code;
      logic              commits;
      logic              overflow;
      logic [LEN_W-1:0]  word_length;
      logic              last;
   } rsp_payload_type;

   // Letter shown for a key after a given number of repeat presses
   function automatic logic [CHAR_W-1:0] letter_of(input logic [KEY_W-1:0]   key,
                                                   input logic [PRESS_W-1:0] press);
      logic [CHAR_W-1:0] base;
      unique case (key)
         3'd1:    base = CHAR_A;
         3'd2:    base = CHAR_E;
         3'd3:    base = CHAR_I;
         3'd4:    base = CHAR_M;
         3'd5:    base = CHAR_Q;
         3'd6:    base = CHAR_U;
         3'd7:    base = CHAR_Y;
         default: base = CHAR_NUL;
      endcase
      return base + {{(CHAR_W-PRESS_W){1'b0}}, press};
   endfunction

endpackage
`default_nettype wire

@@ hdl/mtk_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mtk_if
// Valid/ready channel interfaces: key events in, display writes out, and the
// timeout register write port.
// ----------------------------------------------------------------------------
interface mtk_req_if import mtk_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CMD_W-1:0] cmd;
   logic [KEY_W-1:0] key_number;

   modport source (output valid, cmd, key_number, input ready);
   modport sink   (input valid, cmd, key_number, output ready);
endinterface

interface mtk_rsp_if import mtk_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [LEN_W-1:0]  write_pos;
   logic [CHAR_W-1:0] char_code;
   logic              commits;
   logic              overflow;
   logic [LEN_W-1:0]  word_length;
   logic              last;

   modport source (output valid, write_pos, char_code, commits, overflow, word_length, last,
                   input ready);
   modport sink   (input valid, write_pos, char_code, commits, overflow, word_length, last,
                   output ready);
endinterface

interface mtk_csr_if import mtk_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [TIMEOUT_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

@@ hdl/multi_tap_key_entry_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// multi_tap_key_entry_unit
// Multi-tap text entry from seven letter keys with timeout commit and erase.
// ----------------------------------------------------------------------------
// Each accepted event (tick, key press or submit) is decoded in the cycle it
// is taken and produces zero, one or two display writes, which go into a
// four-entry result queue. The queue hands out one write per cycle while
// rsp.ready is high; an event that makes two writes (key switch with commit,
// or erase) takes longer to drain than others. req.ready stays high while
// at most two writes are queued, so events keep flowing while the display
// side stalls briefly. The timeout register port is always ready.
module multi_tap_key_entry_unit import mtk_pkg::*; (
   input wire logic   clock,
   input wire logic   reset,
   mtk_req_if.sink    req,
   mtk_rsp_if.source  rsp,
   mtk_csr_if.sink    csr
);

   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = QPTR_W + 1;

   logic [TIMEOUT_W-1:0] timeout_ff;
   logic [KEY_W-1:0]     pend_key_ff, pend_key_in;
   logic [PRESS_W-1:0]   press_ff, press_in;
   logic [WAIT_W-1:0]    wait_ff, wait_in;
   logic [LEN_W-1:0]     len_ff, len_in;

   rsp_payload_type      queue_ff [QDEPTH];
   logic [QPTR_W-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]    count_ff, count_in;

   logic                 req_xfer, rsp_xfer;
   logic [1:0]           n_res;
   rsp_payload_type      res0, res1, commit_res;

   logic [TIMEOUT_W-1:0] limit;
   logic [WAIT_W-1:0]    wait_inc;
   logic                 com_ovf;
   logic [LEN_W-1:0]     com_len;
   logic                 sw;
   logic                 erase;
   logic [PRESS_W-1:0]   press_new;
   logic [LEN_W-1:0]     len1, len_dec;

   assign csr.ready = 1'b1;
   assign req.ready = (count_ff <= QCNT_W'(QDEPTH - 2));
   assign req_xfer  = req.valid && req.ready;
   assign rsp_xfer  = rsp.valid && rsp.ready;

   always_comb begin
      limit    = (timeout_ff == '0) ? TIMEOUT_MIN : timeout_ff;
      wait_inc = wait_ff + 1'b1;
      com_ovf  = (len_ff >= MAX_WORD);
      com_len  = com_ovf ? len_ff : len_ff + 1'b1;

      commit_res.write_pos   = len_ff;
      commit_res.char_code   = letter_of(pend_key_ff, press_ff);
      commit_res.commits     = !com_ovf;
      commit_res.overflow    = com_ovf;
      commit_res.word_length = com_len;
      commit_res.last        = 1'b0;

      // a different key commits the pending letter first
      sw        = (pend_key_ff != KEY_NONE) && (pend_key_ff != req.key_number);
      press_new = (pend_key_ff == req.key_number) ? press_ff + 1'b1 : '0;
      len1      = sw ? com_len : len_ff;
      len_dec   = (len1 == '0) ? '0 : len1 - 1'b1;
      erase     = (req.key_number == KEY_ERASE) && (press_new >= ERASE_PRESS);

      pend_key_in = pend_key_ff;
      press_in    = press_ff;
      wait_in     = wait_ff;
      len_in      = len_ff;
      res0        = '0;
      res1        = '0;
      n_res       = 2'd0;

      if (req_xfer) begin
         unique case (req.cmd)
            CMD_TICK: begin
               if (pend_key_ff != KEY_NONE) begin
                  if (wait_inc >= limit) begin
                     res0        = commit_res;
                     n_res       = 2'd1;
                     len_in      = com_len;
                     pend_key_in = KEY_NONE;
                     press_in    = '0;
                     wait_in     = '0;
                  end else begin
                     wait_in = wait_inc;
                  end
               end
            end
            CMD_KEY: begin
               if (req.key_number != KEY_NONE) begin
                  wait_in = '0;
                  if (erase) begin
                     // clear the preview, then step back over the last letter
                     res0        = '{len1, CHAR_SPACE, 1'b0, 1'b0, len1, 1'b0};
                     res1        = '{len_dec, CHAR_SPACE, 1'b0, 1'b0, len_dec, 1'b0};
                     n_res       = 2'd2;
                     len_in      = len_dec;
                     pend_key_in = KEY_NONE;
                     press_in    = '0;
                  end else begin
                     pend_key_in = req.key_number;
                     press_in    = press_new;
                     len_in      = len1;
                     if (sw) begin
                        res0  = commit_res;
                        res1  = '{len1, letter_of(req.key_number, press_new), 1'b0, 1'b0,
                                  len1, 1'b0};
                        n_res = 2'd2;
                     end else begin
                        res0  = '{len1, letter_of(req.key_number, press_new), 1'b0, 1'b0,
                                  len1, 1'b0};
                        n_res = 2'd1;
                     end
                  end
               end
            end
            CMD_SUBMIT: begin
               len_in = '0;
            end
            default: begin
            end
         endcase
      end

      if (n_res == 2'd1) begin
         res0.last = 1'b1;
      end
      if (n_res == 2'd2) begin
         res1.last = 1'b1;
      end

      count_in = count_ff + QCNT_W'(n_res) - QCNT_W'(rsp_xfer);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff  <= TIMEOUT_RESET;
         pend_key_ff <= KEY_NONE;
         press_ff    <= '0;
         wait_ff     <= '0;
         len_ff      <= '0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
      end else begin
         if (csr.valid && csr.ready) begin
            timeout_ff <= csr.data;
         end
         pend_key_ff <= pend_key_in;
         press_ff    <= press_in;
         wait_ff     <= wait_in;
         len_ff      <= len_in;
         wr_ptr_ff   <= wr_ptr_ff + QPTR_W'(n_res);
         count_ff    <= count_in;
         if (rsp_xfer) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   // result queue storage
   always_ff @(posedge clock) begin
      if (n_res != 2'd0) begin
         queue_ff[wr_ptr_ff] <= res0;
      end
      if (n_res == 2'd2) begin
         queue_ff[wr_ptr_ff + 1'b1] <= res1;
      end
   end

   assign rsp.valid       = (count_ff != '0);
   assign rsp.write_pos   = queue_ff[rd_ptr_ff].write_pos;
   assign rsp.char_code   = queue_ff[rd_ptr_ff].char_code;
   assign rsp.commits     = queue_ff[rd_ptr_ff].commits;
   assign rsp.overflow    = queue_ff[rd_ptr_ff].overflow;
   assign rsp.word_length = queue_ff[rd_ptr_ff].word_length;
   assign rsp.last        = queue_ff[rd_ptr_ff].last;

endmodule
`default_nettype wire
